// ===== hw/rtl/atan_pkg.sv =====
// Shared constants, tag types and rounding helper for the arctangent unit.
`default_nettype none
package atan_pkg;

	localparam int XW = 32;
	localparam int AW = 31;

	localparam logic [31:0] T6_Q30    = 32'd619925131;
	localparam logic [31:0] T12_Q30   = 32'd287708255;
	localparam logic [31:0] PI6_Q30   = 32'd562209904;
	localparam logic [31:0] PI2_Q30   = 32'd1686629713;
	localparam logic [31:0] C1_Q24    = 32'd817068372;
	localparam logic [31:0] C2_Q24    = 32'd831019572;
	localparam logic [31:0] C3_Q24    = 32'd157807206;
	localparam logic [31:0] C4_Q24    = 32'd817068372;
	localparam logic [31:0] C5_Q24    = 32'd1103375696;
	localparam logic [31:0] C6_Q24    = 32'd362185433;
	localparam logic [31:0] ANGLE_MAX = 32'd843314857;
	localparam logic [30:0] ONE_Q16   = 31'd65536;
	localparam logic [30:0] A_SAT     = 31'h7FFFFFFF;

	localparam int RECIP_QW = 30;
	localparam int SHIFT_QW = 30;
	localparam int RATIO_QW = 32;

	typedef struct packed {
		logic        neg;
		logic        comp;
		logic [16:0] a_lo;
	} tag_recip_t;

	typedef struct packed {
		logic        neg;
		logic        comp;
		logic        region;
		logic        wneg;
		logic [30:0] mag;
	} tag_arg_t;

	// Product in Q60 back to Q30, rounded half up; every caller's result fits 32 bits.
	function automatic logic [31:0] rnd30(input logic [63:0] p);
		logic [63:0] s;
		s = p + 64'd536870912;
		return s[61:30];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/atan_if.sv =====
// Stream interfaces for the argument and the angle channels.
`default_nettype none
interface atan_x_if;
	logic                             valid;
	logic                             ready;
	logic signed [atan_pkg::XW-1:0]   x_value;
	modport source (output valid, output x_value, input ready);
	modport sink (input valid, input x_value, output ready);
endinterface

interface atan_angle_if;
	logic                             valid;
	logic                             ready;
	logic signed [atan_pkg::AW-1:0]   angle;
	modport source (output valid, output angle, input ready);
	modport sink (input valid, input angle, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/atan_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a tag carried alongside.
`default_nettype none
module atan_div #(
	parameter int DW = 64,
	parameter int VW = 32,
	parameter int QW = 32,
	parameter int TW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	input  wire logic [TW-1:0] tag_in,
	output logic               out_valid,
	output logic [QW-1:0]      quot,
	output logic [TW-1:0]      tag_out
);

	logic [VW-1:0] rem  [QW+1];
	logic [QW-1:0] low  [QW+1];
	logic [VW-1:0] dv   [QW+1];
	logic [TW-1:0] tg   [QW+1];
	logic          vl   [QW+1];

	// The quotient must fit in QW bits, so the upper dividend bits start below the divisor.
	assign rem[0] = VW'(dividend[DW-1:QW]);
	assign low[0] = dividend[QW-1:0];
	assign dv[0]  = divisor;
	assign tg[0]  = tag_in;
	assign vl[0]  = in_valid;

	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [VW:0] trial;
		logic [VW:0] diff;
		logic        ge;

		always_comb begin
			trial = {rem[k-1], low[k-1][QW-1]};
			diff  = trial - {1'b0, dv[k-1]};
			ge    = (trial >= {1'b0, dv[k-1]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vl[k] <= 1'b0;
			end else if (en) begin
				vl[k] <= vl[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem[k] <= ge ? diff[VW-1:0] : trial[VW-1:0];
				low[k] <= {low[k-1][QW-2:0], ge};
				dv[k]  <= dv[k-1];
				tg[k]  <= tg[k-1];
			end
		end
	end

	assign out_valid = vl[QW];
	assign quot      = low[QW];
	assign tag_out   = tg[QW];

endmodule
`default_nettype wire

// ===== hw/rtl/arctangent_rational_approx.sv =====
// Arctangent of a Q16.16 word as a Q2.29 angle, reciprocal and pi/6 reduction, 3/3 rational fit.
// Throughput: one word per cycle; the three dividers and the multipliers are fully pipelined.
// The whole pipeline advances together and holds while the output word waits to be taken.
// Reset clears all valid bits asynchronously; data registers are not reset.
`default_nettype none
module arctangent_rational_approx (
	input  wire logic     clk,
	input  wire logic     arst_n,
	atan_x_if.sink        arg,
	atan_angle_if.source  result
);
	import atan_pkg::*;

	logic en;

	// Stage 1: magnitude and reciprocal decision.
	logic [31:0] mag_c;
	logic [30:0] a_c;
	logic        vld_s1, neg_s1, comp_s1;
	logic [30:0] a_s1;
	logic [46:0] d1_c;
	tag_recip_t  t1_c, t1_o;
	logic        v1_o;
	logic [29:0] q1_o;

	// Stages 2-4: argument shift setup.
	logic        vld_s2, vld_s3, vld_s4;
	logic [30:0] v_c, v_s2, v_s3;
	logic        neg_s2, comp_s2, neg_s3, comp_s3, neg_s4, comp_s4;
	logic [63:0] prod_s3;
	logic        region_s3, wneg_s3, region_s4, wneg_s4;
	logic [30:0] mmag_s3, mmag_s4, v_s4;
	logic [31:0] n_s4;
	logic [61:0] d2_c;
	tag_arg_t    t2_c, t2_o;
	logic        v2_o;
	logic [29:0] q2_o;

	// Stages 5-13: square and Horner evaluation.
	tag_arg_t    a_s5, a_s6, a_s7, a_s8, a_s9, a_s10, a_s11, a_s12, a_s13;
	logic        vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13;
	logic [63:0] sq_s6;
	logic [30:0] w2_s7, w2_s8, w2_s9, w2_s10, w2_s11;
	logic [31:0] w2r_c;
	logic [63:0] pn1_s8, pn2_s10, pd2_s10, pd3_s12;
	logic [31:0] d1_s8, d1_s9, n1_s9, num_s11, num_s12, num_s13, d2_s11, den_s13;
	logic [63:0] d3_c;
	tag_arg_t    t3_o;
	logic        v3_o;
	logic [31:0] q3_o;

	// Stages 14-17: angle assembly.
	logic        vld_s14, vld_s15, vld_s16, vld_s17;
	tag_arg_t    a_s14, a_s15;
	logic [63:0] py_s14;
	logic [31:0] ymag_s15;
	logic signed [34:0] y0, y1, y2, y3, r0, rc, fin;
	logic signed [34:0] y2_s16;
	logic        neg_s16;
	logic [30:0] angle_s17;

	assign en        = !vld_s17 || result.ready;
	assign arg.ready = en;

	always_comb begin
		mag_c = 32'd0 - arg.x_value;
		if (arg.x_value == 32'sh80000000) begin
			a_c = A_SAT;
		end else if (arg.x_value[31]) begin
			a_c = mag_c[30:0];
		end else begin
			a_c = arg.x_value[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
			vld_s17 <= 1'b0;
		end else if (en) begin
			vld_s1  <= arg.valid;
			vld_s2  <= v1_o;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= v2_o;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= v3_o;
			vld_s15 <= vld_s14;
			vld_s16 <= vld_s15;
			vld_s17 <= vld_s16;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= arg.x_value[31];
			comp_s1 <= (a_c > ONE_Q16);
			a_s1    <= a_c;
		end
	end

	// Reciprocal 2^46 / a, rounded.
	assign d1_c = {1'b1, 46'd0} + {17'd0, a_s1[30:1]};
	assign t1_c = '{neg: neg_s1, comp: comp_s1, a_lo: a_s1[16:0]};

	atan_div #(.DW(47), .VW(31), .QW(RECIP_QW), .TW($bits(tag_recip_t))) u_div_recip (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s1), .dividend(d1_c), .divisor(a_s1), .tag_in(t1_c),
		.out_valid(v1_o), .quot(q1_o), .tag_out(t1_o)
	);

	assign v_c = t1_o.comp ? {1'b0, q1_o} : {t1_o.a_lo, 14'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			v_s2    <= v_c;
			neg_s2  <= t1_o.neg;
			comp_s2 <= t1_o.comp;

			prod_s3   <= 64'(T6_Q30) * 64'(v_s2);
			region_s3 <= ({1'b0, v_s2} > T12_Q30);
			wneg_s3   <= ({1'b0, v_s2} < T6_Q30);
			mmag_s3   <= ({1'b0, v_s2} >= T6_Q30) ? (v_s2 - T6_Q30[30:0])
				: (T6_Q30[30:0] - v_s2);
			v_s3      <= v_s2;
			neg_s3    <= neg_s2;
			comp_s3   <= comp_s2;

			n_s4      <= 32'd1073741824 + rnd30(prod_s3);
			mmag_s4   <= mmag_s3;
			region_s4 <= region_s3;
			wneg_s4   <= wneg_s3;
			v_s4      <= v_s3;
			neg_s4    <= neg_s3;
			comp_s4   <= comp_s3;
		end
	end

	// Shifted argument (v - t) / (1 + t*v), rounded half away from zero on the magnitude.
	assign d2_c = {1'b0, mmag_s4, 30'd0} + {31'd0, n_s4[31:1]};
	assign t2_c = '{neg: neg_s4, comp: comp_s4, region: region_s4, wneg: wneg_s4, mag: v_s4};

	atan_div #(.DW(62), .VW(32), .QW(SHIFT_QW), .TW($bits(tag_arg_t))) u_div_shift (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s4), .dividend(d2_c), .divisor(n_s4), .tag_in(t2_c),
		.out_valid(v2_o), .quot(q2_o), .tag_out(t2_o)
	);

	assign w2r_c = {1'b0, w2_s7} + 32'd32;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s5.neg    <= t2_o.neg;
			a_s5.comp   <= t2_o.comp;
			a_s5.region <= t2_o.region;
			a_s5.wneg   <= t2_o.region && t2_o.wneg && (q2_o != 30'd0);
			a_s5.mag    <= t2_o.region ? {1'b0, q2_o} : t2_o.mag;

			sq_s6 <= 64'(a_s5.mag) * 64'(a_s5.mag);
			a_s6  <= a_s5;

			w2_s7 <= 31'(rnd30(sq_s6));
			a_s7  <= a_s6;

			pn1_s8 <= 64'(w2_s7) * 64'(C3_Q24);
			d1_s8  <= C6_Q24 + {6'd0, w2r_c[31:6]};
			w2_s8  <= w2_s7;
			a_s8   <= a_s7;

			n1_s9 <= C2_Q24 + rnd30(pn1_s8);
			d1_s9 <= d1_s8;
			w2_s9 <= w2_s8;
			a_s9  <= a_s8;

			pn2_s10 <= 64'(w2_s9) * 64'(n1_s9);
			pd2_s10 <= 64'(w2_s9) * 64'(d1_s9);
			w2_s10  <= w2_s9;
			a_s10   <= a_s9;

			num_s11 <= C1_Q24 + rnd30(pn2_s10);
			d2_s11  <= C5_Q24 + rnd30(pd2_s10);
			w2_s11  <= w2_s10;
			a_s11   <= a_s10;

			pd3_s12 <= 64'(w2_s11) * 64'(d2_s11);
			num_s12 <= num_s11;
			a_s12   <= a_s11;

			den_s13 <= C4_Q24 + rnd30(pd3_s12);
			num_s13 <= num_s12;
			a_s13   <= a_s12;
		end
	end

	// Ratio of the two polynomials, Q30, rounded.
	assign d3_c = {2'b00, num_s13, 30'd0} + {33'd0, den_s13[31:1]};

	atan_div #(.DW(64), .VW(32), .QW(RATIO_QW), .TW($bits(tag_arg_t))) u_div_ratio (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s13), .dividend(d3_c),
		.divisor(den_s13), .tag_in(a_s13),
		.out_valid(v3_o), .quot(q3_o), .tag_out(t3_o)
	);

	always_comb begin
		y0 = a_s15.wneg ? -$signed({3'b000, ymag_s15}) : $signed({3'b000, ymag_s15});
		y1 = a_s15.region ? y0 + $signed({3'b000, PI6_Q30}) : y0;
		y2 = a_s15.comp ? $signed({3'b000, PI2_Q30}) - y1 : y1;
	end

	always_comb begin
		y3 = (y2_s16 < 35'sd0) ? 35'sd0 : y2_s16;
		r0 = (y3 + 35'sd1) >>> 1;
		rc = (r0 > $signed({3'b000, ANGLE_MAX})) ? $signed({3'b000, ANGLE_MAX}) : r0;
		fin = neg_s16 ? -rc : rc;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			py_s14   <= 64'(t3_o.mag) * 64'(q3_o);
			a_s14    <= t3_o;
			ymag_s15 <= rnd30(py_s14);
			a_s15    <= a_s14;
			y2_s16   <= y2;
			neg_s16  <= a_s15.neg;
			angle_s17 <= fin[30:0];
		end
	end

	assign result.valid = vld_s17;
	assign result.angle = angle_s17;

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ($signed(result.angle) <= $signed(ANGLE_MAX[30:0])
			&& $signed(result.angle) >= -$signed(ANGLE_MAX[30:0])))
		else $error("angle word outside range");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!arg.ready |-> (result.valid && !result.ready))
		else $error("input stalled without a waiting output word");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> $stable(vld_s15) && $stable(ymag_s15))
		else $error("pipeline moved during a stall");

endmodule
`default_nettype wire

// ===== dv/arctangent_rational_approx_test.sv =====
// Self-checking testbench for the arctangent unit: random and directed arguments, predicted angles.
`timescale 1ns / 1ps
`default_nettype none
module arctangent_rational_approx_test;
	import atan_pkg::*;

	localparam int LATENCY = 109;

	logic clk;
	logic arst_n;
	atan_x_if     arg ();
	atan_angle_if result ();

	arctangent_rational_approx dut (
		.clk    (clk),
		.arst_n (arst_n),
		.arg    (arg),
		.result (result)
	);

	logic [31:0] pending_args[$];
	logic [30:0] expected_angles[$];
	int          errors;
	bit          stimulus_done;
	int          send_gap;
	int          take_gap;

	// Q60 product back to Q30, rounded half up.
	function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
		return (a * b + 64'd536870912) >> 30;
	endfunction

	function automatic logic [30:0] atan_angle(input logic [31:0] x);
		logic        neg;
		logic        wneg;
		logic        region;
		logic        comp;
		logic [63:0] a, v, n, mmag, wmag, w2, num, den, r, ymag;
		longint      y, res;
		neg = x[31];
		wneg = 1'b0;
		region = 1'b0;
		comp = 1'b0;
		if (neg) begin
			a = 64'h1_0000_0000 - {32'd0, x};
			if (a > 64'h7FFF_FFFF)
				a = 64'h7FFF_FFFF;
		end else
			a = {32'd0, x};
		if (a > 64'd65536) begin
			v = ((64'd1 << 46) + (a >> 1)) / a;
			comp = 1'b1;
		end else
			v = a << 14;
		if (v > 64'(T12_Q30)) begin
			n = (64'd1 << 30) + mulq(64'(T6_Q30), v);
			if (v >= 64'(T6_Q30))
				mmag = v - 64'(T6_Q30);
			else begin
				mmag = 64'(T6_Q30) - v;
				wneg = 1'b1;
			end
			wmag = ((mmag << 30) + (n >> 1)) / n;
			if (wmag == 0)
				wneg = 1'b0;
			region = 1'b1;
		end else
			wmag = v;
		w2 = mulq(wmag, wmag);
		num = 64'(C3_Q24);
		num = 64'(C2_Q24) + mulq(w2, num);
		num = 64'(C1_Q24) + mulq(w2, num);
		den = 64'd1 << 24;
		den = 64'(C6_Q24) + mulq(w2, den);
		den = 64'(C5_Q24) + mulq(w2, den);
		den = 64'(C4_Q24) + mulq(w2, den);
		r = ((num << 30) + (den >> 1)) / den;
		ymag = mulq(wmag, r);
		y = wneg ? -longint'(ymag) : longint'(ymag);
		if (region)
			y += longint'(PI6_Q30);
		if (comp)
			y = longint'(PI2_Q30) - y;
		if (y < 0)
			y = 0;
		res = (y + 1) >>> 1;
		if (res > longint'(ANGLE_MAX))
			res = longint'(ANGLE_MAX);
		if (neg)
			res = -res;
		return res[30:0];
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		logic [31:0] x;
		arst_n = 1'b0;
		errors = 0;
		stimulus_done = 1'b0;
		// Directed words: zero, ones, both extremes, region borders.
		pending_args.push_back(32'h0000_0000);
		pending_args.push_back(32'h0001_0000);
		pending_args.push_back(32'hFFFF_0000);
		pending_args.push_back(32'h8000_0000);
		pending_args.push_back(32'h8000_0001);
		pending_args.push_back(32'h7FFF_FFFF);
		pending_args.push_back(32'h0000_0001);
		pending_args.push_back(32'hFFFF_FFFF);
		pending_args.push_back(32'h0000_4498);
		pending_args.push_back(32'h0000_4499);
		pending_args.push_back(32'h0000_93CD);
		pending_args.push_back(32'h0001_BB68);
		pending_args.push_back(32'h0003_BB68);
		pending_args.push_back(32'h0001_0001);
		pending_args.push_back(32'h0000_FFFF);
		pending_args.push_back(32'hFFFC_44A0);
		pending_args.push_back(32'h5555_AAAA);
		pending_args.push_back(32'hAAAA_5555);
		for (int i = 0; i < 1200; i++) begin
			case ($urandom_range(0, 3))
				0: x = $urandom();
				1: x = $urandom_range(0, 32'h0002_0000);
				2: x = -$urandom_range(0, 32'h0002_0000);
				default: x = $urandom() >> $urandom_range(0, 31);
			endcase
			pending_args.push_back(x);
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_args.size() == 0 && !arg.valid);
		stimulus_done = 1'b1;
	end

	// Driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arg.valid <= 1'b0;
			arg.x_value <= '0;
			send_gap <= 0;
		end else begin
			if (arg.valid && arg.ready)
				expected_angles.push_back(atan_angle(arg.x_value));
			if (!arg.valid || arg.ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					arg.valid <= 1'b0;
				end else if (pending_args.size() > 0) begin
					arg.valid <= 1'b1;
					arg.x_value <= pending_args.pop_front();
					send_gap <= pick_gap();
				end else
					arg.valid <= 1'b0;
			end
		end
	end

	// Monitor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			take_gap <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_angles.size() == 0) begin
					$display("%0t: unexpected angle word %h", $time, result.angle);
					errors++;
				end else begin
					logic [30:0] want;
					want = expected_angles.pop_front();
					if (result.angle !== want) begin
						$display("%0t: angle expected %h actual %h", $time, want,
							result.angle);
						errors++;
					end
				end
			end
			if (take_gap > 0) begin
				take_gap <= take_gap - 1;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
				take_gap <= pick_gap();
			end
		end
	end

	initial begin
		wait (stimulus_done);
		wait (expected_angles.size() == 0);
		repeat (LATENCY + 50) @(posedge clk);
		if (errors == 0)
			$display("arctangent_rational_approx_test: clean");
		else
			$display("arctangent_rational_approx_test: errors");
		$finish;
	end

	initial begin
		#5ms;
		$display("arctangent_rational_approx_test: errors");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/atan_pkg.sv
hw/rtl/atan_if.sv
hw/rtl/atan_div.sv
hw/rtl/arctangent_rational_approx.sv
dv/arctangent_rational_approx_test.sv
